// ===== rtl/gcc_pkg.sv =====
package gcc_pkg;

  // Default size of the adjacency matrix.
  localparam int MAX_VERTICES_DEF = 64;

  // Field widths fixed by the interface.
  localparam int KIND_W   = 3;
  localparam int VERTEX_W = 6;
  localparam int VCOUNT_W = 7;
  localparam int TALLY_W  = 20;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
  localparam logic [TALLY_W-1:0]  TALLY_MAX    = 20'hFFFFF;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEST   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EDGES  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRI    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_K4     = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic                remove_found;
    logic [VERTEX_W-1:0] vertex_u;
    logic [VERTEX_W-1:0] vertex_v;
  } in_item_t;

  typedef struct packed {
    logic               edge_present;
    logic [TALLY_W-1:0] tally;
    logic               status;
  } out_item_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_E_RD,
    OP_E_WU,
    OP_E_WV,
    OP_RD_A,
    OP_LD_A,
    OP_NEXT_A,
    OP_RD_B,
    OP_LD_B,
    OP_NEXT_B,
    OP_CNT_B,
    OP_RD_C,
    OP_LD_C,
    OP_NEXT_C,
    OP_CNT_C,
    OP_NEXT_D,
    OP_CNT_D,
    OP_HIT_D,
    OP_WR_D,
    OP_WR_C,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              strip;
    logic              edge_bad;
    logic              a_end;
    logic              b_end;
    logic              c_end;
    logic              d_end;
    logic              bit_ab;
    logic              bit_c;
    logic              bit_d;
    logic              out_free;
  } stat_t;

endpackage

// ===== rtl/gcc_ctrl.sv =====
module gcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  gcc_pkg::stat_t    stat,
  output gcc_pkg::cmd_t     cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_EDGE_RD = 14'b00000000000010,
    S_EDGE_WU = 14'b00000000000100,
    S_EDGE_WV = 14'b00000000001000,
    S_A       = 14'b00000000010000,
    S_LD_A    = 14'b00000000100000,
    S_B       = 14'b00000001000000,
    S_LD_B    = 14'b00000010000000,
    S_C       = 14'b00000100000000,
    S_LD_C    = 14'b00001000000000,
    S_D       = 14'b00010000000000,
    S_WR_D    = 14'b00100000000000,
    S_WR_C    = 14'b01000000000000,
    S_EMIT    = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cmd.op     = gcc_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = gcc_pkg::OP_LOAD;
          state_next = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        // The item kind is held in the datapath from here on.
        if (stat.kind == gcc_pkg::KIND_ADD || stat.kind == gcc_pkg::KIND_REMOVE ||
            stat.kind == gcc_pkg::KIND_TEST) begin
          if (stat.edge_bad) begin
            cmd.op = gcc_pkg::OP_ERR;
            state_next = S_EMIT;
          end else begin
            cmd.op = gcc_pkg::OP_E_RD;
            state_next = S_EDGE_WU;
          end
        end else if (stat.kind == gcc_pkg::KIND_EDGES || stat.kind == gcc_pkg::KIND_TRI ||
                     stat.kind == gcc_pkg::KIND_K4) begin
          state_next = S_A;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EDGE_WU: begin
        cmd.op = gcc_pkg::OP_E_WU;
        state_next = (stat.kind == gcc_pkg::KIND_TEST) ? S_EMIT : S_EDGE_WV;
      end
      S_EDGE_WV: begin
        cmd.op = gcc_pkg::OP_E_WV;
        state_next = S_EMIT;
      end
      S_A: begin
        if (stat.a_end) begin
          state_next = S_EMIT;
        end else begin
          cmd.op = gcc_pkg::OP_RD_A;
          state_next = S_LD_A;
        end
      end
      S_LD_A: begin
        cmd.op = gcc_pkg::OP_LD_A;
        state_next = S_B;
      end
      S_B: begin
        if (stat.b_end) begin
          cmd.op = gcc_pkg::OP_NEXT_A;
          state_next = S_A;
        end else if (stat.bit_ab) begin
          if (stat.kind == gcc_pkg::KIND_EDGES) begin
            cmd.op = gcc_pkg::OP_CNT_B;
          end else begin
            cmd.op = gcc_pkg::OP_RD_B;
            state_next = S_LD_B;
          end
        end else begin
          cmd.op = gcc_pkg::OP_NEXT_B;
        end
      end
      S_LD_B: begin
        cmd.op = gcc_pkg::OP_LD_B;
        state_next = S_C;
      end
      S_C: begin
        if (stat.c_end) begin
          cmd.op = gcc_pkg::OP_NEXT_B;
          state_next = S_B;
        end else if (stat.bit_c) begin
          if (stat.kind == gcc_pkg::KIND_TRI) begin
            cmd.op = gcc_pkg::OP_CNT_C;
          end else begin
            cmd.op = gcc_pkg::OP_RD_C;
            state_next = S_LD_C;
          end
        end else begin
          cmd.op = gcc_pkg::OP_NEXT_C;
        end
      end
      S_LD_C: begin
        cmd.op = gcc_pkg::OP_LD_C;
        state_next = S_D;
      end
      S_D: begin
        if (stat.d_end) begin
          if (stat.strip) begin
            state_next = S_WR_C;
          end else begin
            cmd.op = gcc_pkg::OP_NEXT_C;
            state_next = S_C;
          end
        end else if (stat.bit_d) begin
          if (stat.strip) begin
            cmd.op = gcc_pkg::OP_HIT_D;
            state_next = S_WR_D;
          end else begin
            cmd.op = gcc_pkg::OP_CNT_D;
          end
        end else begin
          cmd.op = gcc_pkg::OP_NEXT_D;
        end
      end
      S_WR_D: begin
        cmd.op = gcc_pkg::OP_WR_D;
        state_next = S_D;
      end
      S_WR_C: begin
        cmd.op = gcc_pkg::OP_WR_C;
        state_next = S_C;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = gcc_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gcc_dpath.sv =====
module gcc_dpath #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gcc_pkg::in_item_t              in_data,
  input  logic                           cfg_valid,
  input  logic [gcc_pkg::VCOUNT_W-1:0]   cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output gcc_pkg::out_item_t             out_data,
  input  gcc_pkg::cmd_t                  cmd,
  output gcc_pkg::stat_t                 stat
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef logic [MAX_VERTICES-1:0] row_t;

  // Adjacency memory with one valid bit per row; an unwritten row reads as empty.
  row_t            mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  row_t            rd_raw;
  logic            rd_ok;
  row_t            rd_data;
  logic            we;
  logic [AW-1:0]   waddr;
  row_t            wdata;
  logic [AW-1:0]   raddr;

  // Item and scan registers.
  logic [gcc_pkg::VCOUNT_W-1:0] vertex_count;
  logic [gcc_pkg::KIND_W-1:0]   kind;
  logic                         strip;
  logic [gcc_pkg::VERTEX_W-1:0] vu;
  logic [gcc_pkg::VERTEX_W-1:0] vv;
  logic [CW-1:0]                n;
  logic [CW-1:0]                ia, ib, ic, id;
  row_t                         ra, ab, rc;
  logic [gcc_pkg::TALLY_W-1:0]  tally;
  logic [gcc_pkg::TALLY_W-1:0]  tally_inc;
  logic                         present;
  logic                         err;
  logic [CW-1:0]                n_next;
  logic [AW-1:0]                u_idx, v_idx;

  assign u_idx = AW'(vu);
  assign v_idx = AW'(vv);
  assign tally_inc = (tally == gcc_pkg::TALLY_MAX) ? tally : tally + 1'b1;

  // Effective vertex count, saturated at the matrix size.
  always_comb begin
    if (32'(vertex_count) > MAX_VERTICES) begin
      n_next = CW'(MAX_VERTICES);
    end else begin
      n_next = CW'(vertex_count);
    end
  end

  // Memory write port and read address by operation.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rd_data;
    raddr = '0;
    unique case (cmd.op)
      gcc_pkg::OP_E_RD: begin
        raddr = u_idx;
      end
      gcc_pkg::OP_E_WU: begin
        raddr = v_idx;
        waddr = u_idx;
        we    = (kind != gcc_pkg::KIND_TEST);
        wdata[v_idx] = (kind == gcc_pkg::KIND_ADD);
      end
      gcc_pkg::OP_E_WV: begin
        waddr = v_idx;
        we    = 1'b1;
        wdata[u_idx] = (kind == gcc_pkg::KIND_ADD);
      end
      gcc_pkg::OP_RD_A: raddr = ia[AW-1:0];
      gcc_pkg::OP_RD_B: raddr = ib[AW-1:0];
      gcc_pkg::OP_RD_C: raddr = ic[AW-1:0];
      gcc_pkg::OP_HIT_D: raddr = id[AW-1:0];
      gcc_pkg::OP_WR_D: begin
        waddr = id[AW-1:0];
        we    = 1'b1;
        wdata[ic[AW-1:0]] = 1'b0;
      end
      gcc_pkg::OP_WR_C: begin
        waddr = ic[AW-1:0];
        we    = 1'b1;
        wdata = rc;
      end
      default: begin
      end
    endcase
  end

  // Memory array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw <= mem[raddr];
  end

  // Row valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      rd_ok <= row_valid[raddr];
    end
  end

  assign rd_data = rd_ok ? rd_raw : '0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= gcc_pkg::VCOUNT_RESET;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  // Item registers, scan counters and tally.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      gcc_pkg::OP_LOAD: begin
        kind    <= in_data.kind;
        strip   <= in_data.remove_found && (in_data.kind == gcc_pkg::KIND_K4);
        vu      <= in_data.vertex_u;
        vv      <= in_data.vertex_v;
        n       <= n_next;
        ia      <= '0;
        tally   <= '0;
        present <= 1'b0;
        err     <= 1'b0;
      end
      gcc_pkg::OP_ERR: err <= 1'b1;
      gcc_pkg::OP_E_WU: present <= (kind == gcc_pkg::KIND_TEST) && rd_data[v_idx];
      gcc_pkg::OP_LD_A: begin
        ra <= rd_data;
        ib <= ia + 1'b1;
      end
      gcc_pkg::OP_NEXT_A: ia <= ia + 1'b1;
      gcc_pkg::OP_LD_B: begin
        ab <= ra & rd_data;
        ic <= ib + 1'b1;
      end
      gcc_pkg::OP_NEXT_B: ib <= ib + 1'b1;
      gcc_pkg::OP_CNT_B: begin
        tally <= tally_inc;
        ib    <= ib + 1'b1;
      end
      gcc_pkg::OP_LD_C: begin
        rc <= rd_data;
        id <= ic + 1'b1;
      end
      gcc_pkg::OP_NEXT_C, gcc_pkg::OP_WR_C: ic <= ic + 1'b1;
      gcc_pkg::OP_CNT_C: begin
        tally <= tally_inc;
        ic    <= ic + 1'b1;
      end
      gcc_pkg::OP_NEXT_D, gcc_pkg::OP_WR_D: id <= id + 1'b1;
      gcc_pkg::OP_CNT_D: begin
        tally <= tally_inc;
        id    <= id + 1'b1;
      end
      gcc_pkg::OP_HIT_D: begin
        tally <= tally_inc;
        rc[id[AW-1:0]] <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == gcc_pkg::OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gcc_pkg::OP_EMIT) begin
      out_data.edge_present <= present;
      out_data.tally        <= tally;
      out_data.status       <= err;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.kind     = kind;
    stat.strip    = strip;
    stat.edge_bad = (CW'(vu) >= n) || (CW'(vv) >= n) || (vu == vv) ||
                    (32'(vu) >= MAX_VERTICES) || (32'(vv) >= MAX_VERTICES);
    stat.a_end    = (ia == n);
    stat.b_end    = (ib == n);
    stat.c_end    = (ic == n);
    stat.d_end    = (id == n);
    stat.bit_ab   = ra[ib[AW-1:0]];
    stat.bit_c    = ab[ic[AW-1:0]];
    stat.bit_d    = ab[id[AW-1:0]] & rc[id[AW-1:0]];
    stat.out_free = !out_valid || out_ready;
  end

endmodule

// ===== rtl/graph_clique_counter.sv =====
// Channel  Direction  Payload                 Handshake
// in       input      in_data (in_item_t)     in_valid / in_ready
// out      output     out_data (out_item_t)   out_valid / out_ready
// cfg      input      cfg_data (vertex_count) cfg_valid / cfg_ready
//
// Edge add and remove do a row read-modify-write of both end rows through the one write
// port of the memory; a test only reads, and an out-of-range or self-loop item is rejected.
// Counts step through each candidate vertex and loop end and load each row read in a state
// of its own; a K4 count with removal adds a row write per clique found and per third vertex.
// Reset clears the matrix at once through per-row valid bits and sets vertex_count to 64.
// A new item is taken while the previous result still waits in the output register.
module graph_clique_counter #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gcc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gcc_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gcc_pkg::VCOUNT_W-1:0] cfg_data
);

  gcc_pkg::cmd_t  cmd;
  gcc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcc_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // An accepted item holds off the next one; input is never taken back to back.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // A rejected edge item reports nothing else.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> (!out_data.edge_present && out_data.tally == '0))
    else $error("error result carries data");

  // A count result never reports an edge test.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.tally != '0) |-> !out_data.edge_present)
    else $error("count result with edge flag");

endmodule
